[hdl/life_automaton_generation_core_macros.svh]
// Assertion macros for the life automaton generation core.
`ifndef LIFE_AUTOMATON_GENERATION_CORE_MACROS_SVH
`define LIFE_AUTOMATON_GENERATION_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define LAGC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LAGC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LAGC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LAGC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/lagc_pkg.sv]
// Types, codes and constants shared by the life automaton generation core.
package lagc_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam int CFG_DIM_W  = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int COUNT_W    = 13;
   localparam int STAG_W     = 4;

   localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
   localparam logic [STAG_W-1:0]  STAG_MAX   = 4'd15;
   localparam logic [STAG_W-1:0]  STAG_LIMIT = 4'd10;
   localparam logic [3:0]         BIRTH_N    = 4'd3;
   localparam logic [3:0]         SURVIVE_N  = 4'd2;

   localparam logic [CFG_DIM_W-1:0] GRID_WIDTH_RST  = 7'd64;
   localparam logic [CFG_DIM_W-1:0] GRID_HEIGHT_RST = 7'd64;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRAP_EDGES  = 2'd2;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_STEP  = 2'd2;

   typedef struct packed {
      logic [1:0] op;
      logic [5:0] cell_x;
      logic [5:0] cell_y;
      logic       cell_value;
   } req_type;

   typedef struct packed {
      logic               read_value;
      logic [COUNT_W-1:0] live_count;
      logic               stagnant;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL_ACC,
      ST_GEN_TOP,
      ST_GEN_CUR,
      ST_GEN_NXT,
      ST_GEN_CELL,
      ST_GEN_WB,
      ST_GEN_FIN
   } state_type;

endpackage

[hdl/life_automaton_generation_core.sv]
// Game of life generation core: row store, three-row window, one shared cell unit.
// Cell read, write and unused op: one access state, strobe on the edge that ends it;
// no new command is taken while busy. Generation step: strobe on the edge that ends it;
// the cell unit rules one cell a cycle, plus one row read and one row write-back per
// row. Results cannot be held off by the receiver.
// Synchronous active-high reset clears the grid at once via per-row valid bits; no sweep.
`include "life_automaton_generation_core_macros.svh"

module life_automaton_generation_core #(
   parameter int MAX_WIDTH  = lagc_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = lagc_pkg::MAX_HEIGHT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  lagc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output lagc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [lagc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lagc_pkg::CFG_DIM_W-1:0]      csr_wdata
);

   localparam int COL_AW  = $clog2(MAX_WIDTH);
   localparam int ROW_AW  = $clog2(MAX_HEIGHT);
   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int CMP_W   = (DIM_W > lagc_pkg::CFG_DIM_W) ? DIM_W : lagc_pkg::CFG_DIM_W;
   localparam int LIVE_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int EXT_W   = (LIVE_W > lagc_pkg::COUNT_W) ? LIVE_W : lagc_pkg::COUNT_W;

   // configuration
   logic [lagc_pkg::CFG_DIM_W-1:0] cfg_width_ff, cfg_width_in;
   logic [lagc_pkg::CFG_DIM_W-1:0] cfg_height_ff, cfg_height_in;
   logic                           cfg_wrap_ff, cfg_wrap_in;

   // control
   lagc_pkg::state_type            state_ff, state_in;
   logic [MAX_HEIGHT-1:0]          row_valid_ff, row_valid_in;
   logic [lagc_pkg::STAG_W-1:0]    stag_ff, stag_in;
   logic [lagc_pkg::COUNT_W-1:0]   prev_count_ff, prev_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // payload
   lagc_pkg::rsp_type              rsp_data_ff, rsp_data_in;
   logic [1:0]                     op_ff, op_in;
   logic [5:0]                     cx_ff, cx_in;
   logic [5:0]                     cy_ff, cy_in;
   logic                           cv_ff, cv_in;
   logic                           inside_ff, inside_in;
   logic [LIVE_W-1:0]              area_ff, area_in;
   logic [LIVE_W-1:0]              live_ff, live_in;
   logic [COL_AW-1:0]              x_ff, x_in;
   logic [ROW_AW-1:0]              y_ff, y_in;
   logic [MAX_WIDTH-1:0]           prev_ff, prev_in;
   logic [MAX_WIDTH-1:0]           cur_ff, cur_in;
   logic [MAX_WIDTH-1:0]           nxt_ff, nxt_in;
   logic [MAX_WIDTH-1:0]           row0_ff, row0_in;
   logic [MAX_WIDTH-1:0]           new_row_ff, new_row_in;

   // row store
   logic [MAX_WIDTH-1:0]           row_mem [MAX_HEIGHT];
   logic [MAX_WIDTH-1:0]           rd_row_ff;
   logic                           mem_we, mem_re;
   logic [ROW_AW-1:0]              mem_wa, mem_ra;
   logic [MAX_WIDTH-1:0]           mem_wd;

   // derived
   logic [CMP_W-1:0]               gw_ext, gh_ext;
   logic [DIM_W-1:0]               w_eff, h_eff;
   logic [2*DIM_W-1:0]             area_full;
   logic                           req_inside;
   logic [MAX_WIDTH-1:0]           mod_row;
   logic [COL_AW-1:0]              cx_idx;

   // cell unit
   logic [COL_AW-1:0]              xl, xr;
   logic                           xl_ok, xr_ok;
   logic [3:0]                     nsum;
   logic                           alive, cell_next;
   logic                           x_last, y_last, nxt_in_grid;

   // step summary
   logic [EXT_W-1:0]               live_ext;
   logic [lagc_pkg::COUNT_W-1:0]   live_sat;
   logic [LIVE_W+2:0]              five_live;

   assign busy      = (state_ff != lagc_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign gw_ext = CMP_W'(cfg_width_ff);
   assign gh_ext = CMP_W'(cfg_height_ff);
   assign w_eff  = (gw_ext == '0) ? DIM_W'(1) :
                   (gw_ext > CMP_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : DIM_W'(gw_ext);
   assign h_eff  = (gh_ext == '0) ? DIM_W'(1) :
                   (gh_ext > CMP_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : DIM_W'(gh_ext);
   assign area_full  = w_eff * h_eff;
   assign req_inside = (CMP_W'(req_data.cell_x) < CMP_W'(w_eff)) &&
                       (CMP_W'(req_data.cell_y) < CMP_W'(h_eff));

   assign cx_idx = COL_AW'(cx_ff);
   always_comb begin
      mod_row         = rd_row_ff;
      mod_row[cx_idx] = cv_ff;
   end

   // shared cell unit
   assign x_last      = (DIM_W'(x_ff) == (w_eff - DIM_W'(1)));
   assign y_last      = (DIM_W'(y_ff) == (h_eff - DIM_W'(1)));
   assign nxt_in_grid = ((DIM_W'(y_ff) + DIM_W'(1)) < h_eff);
   assign xl_ok       = (x_ff != '0) || cfg_wrap_ff;
   assign xr_ok       = !x_last || cfg_wrap_ff;
   assign xl          = (x_ff == '0) ? COL_AW'(w_eff - DIM_W'(1)) : x_ff - COL_AW'(1);
   assign xr          = x_last ? '0 : x_ff + COL_AW'(1);
   assign alive       = cur_ff[x_ff];
   assign nsum = 4'(prev_ff[xl] & xl_ok) + 4'(prev_ff[x_ff]) + 4'(prev_ff[xr] & xr_ok)
               + 4'(cur_ff[xl] & xl_ok) + 4'(cur_ff[xr] & xr_ok)
               + 4'(nxt_ff[xl] & xl_ok) + 4'(nxt_ff[x_ff]) + 4'(nxt_ff[xr] & xr_ok);
   assign cell_next = alive ? ((nsum == lagc_pkg::SURVIVE_N) || (nsum == lagc_pkg::BIRTH_N))
                            : (nsum == lagc_pkg::BIRTH_N);

   assign live_ext  = EXT_W'(live_ff);
   assign live_sat  = (live_ext > EXT_W'(lagc_pkg::COUNT_MAX)) ? lagc_pkg::COUNT_MAX
                                                               : lagc_pkg::COUNT_W'(live_ext);
   assign five_live = (LIVE_W+3)'({live_ff, 2'b00}) + (LIVE_W+3)'(live_ff);

   always_comb begin
      cfg_width_in  = cfg_width_ff;
      cfg_height_in = cfg_height_ff;
      cfg_wrap_in   = cfg_wrap_ff;
      if (csr_we) begin
         unique case (csr_index)
            lagc_pkg::CSR_GRID_WIDTH:  cfg_width_in  = csr_wdata;
            lagc_pkg::CSR_GRID_HEIGHT: cfg_height_in = csr_wdata;
            lagc_pkg::CSR_WRAP_EDGES:  cfg_wrap_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      row_valid_in  = row_valid_ff;
      stag_in       = stag_ff;
      prev_count_in = prev_count_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      op_in         = op_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      cv_in         = cv_ff;
      inside_in     = inside_ff;
      area_in       = area_ff;
      live_in       = live_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      nxt_in        = nxt_ff;
      row0_in       = row0_ff;
      new_row_in    = new_row_ff;
      mem_we        = 1'b0;
      mem_wa        = y_ff;
      mem_wd        = new_row_ff;
      mem_re        = 1'b0;
      mem_ra        = '0;

      unique case (state_ff)
         lagc_pkg::ST_IDLE: begin
            if (start) begin
               op_in     = req_data.op;
               cx_in     = req_data.cell_x;
               cy_in     = req_data.cell_y;
               cv_in     = req_data.cell_value;
               inside_in = req_inside;
               mem_re    = 1'b1;
               if (req_data.op == lagc_pkg::OP_STEP) begin
                  area_in  = LIVE_W'(area_full);
                  live_in  = '0;
                  y_in     = '0;
                  mem_ra   = ROW_AW'(h_eff - DIM_W'(1));
                  state_in = lagc_pkg::ST_GEN_TOP;
               end else begin
                  mem_ra   = ROW_AW'(req_data.cell_y);
                  state_in = lagc_pkg::ST_CELL_ACC;
               end
            end
         end
         lagc_pkg::ST_CELL_ACC: begin
            if ((op_ff == lagc_pkg::OP_WRITE) && inside_ff) begin
               mem_we               = 1'b1;
               mem_wa               = ROW_AW'(cy_ff);
               mem_wd               = mod_row;
               row_valid_in[mem_wa] = 1'b1;
            end
            rsp_valid_in           = 1'b1;
            rsp_data_in.read_value = (op_ff == lagc_pkg::OP_READ) && inside_ff &&
                                     rd_row_ff[cx_idx];
            rsp_data_in.live_count = '0;
            rsp_data_in.stagnant   = (stag_ff > lagc_pkg::STAG_LIMIT);
            state_in               = lagc_pkg::ST_IDLE;
         end
         lagc_pkg::ST_GEN_TOP: begin
            prev_in  = cfg_wrap_ff ? rd_row_ff : '0;
            mem_re   = 1'b1;
            mem_ra   = '0;
            state_in = lagc_pkg::ST_GEN_CUR;
         end
         lagc_pkg::ST_GEN_CUR: begin
            cur_in   = rd_row_ff;
            row0_in  = rd_row_ff;
            mem_re   = 1'b1;
            mem_ra   = y_ff + ROW_AW'(1);
            state_in = lagc_pkg::ST_GEN_NXT;
         end
         lagc_pkg::ST_GEN_NXT: begin
            if (nxt_in_grid) begin
               nxt_in = rd_row_ff;
            end else begin
               nxt_in = cfg_wrap_ff ? row0_ff : '0;
            end
            x_in       = '0;
            new_row_in = '0;
            state_in   = lagc_pkg::ST_GEN_CELL;
         end
         lagc_pkg::ST_GEN_CELL: begin
            new_row_in[x_ff] = cell_next;
            live_in          = live_ff + LIVE_W'(alive);
            if (x_last) begin
               state_in = lagc_pkg::ST_GEN_WB;
            end else begin
               x_in = x_ff + COL_AW'(1);
            end
         end
         lagc_pkg::ST_GEN_WB: begin
            mem_we             = 1'b1;
            row_valid_in[y_ff] = 1'b1;
            if (y_last) begin
               state_in = lagc_pkg::ST_GEN_FIN;
            end else begin
               prev_in  = cur_ff;
               cur_in   = nxt_ff;
               y_in     = y_ff + ROW_AW'(1);
               mem_re   = 1'b1;
               mem_ra   = y_ff + ROW_AW'(2);
               state_in = lagc_pkg::ST_GEN_NXT;
            end
         end
         lagc_pkg::ST_GEN_FIN: begin
            for (int i = 0; i < MAX_HEIGHT; i++) begin
               row_valid_in[i] = row_valid_ff[i] && (DIM_W'(i) < h_eff);
            end
            if ((live_sat == prev_count_ff) && (five_live < (LIVE_W+3)'(area_ff)) &&
                (stag_ff < lagc_pkg::STAG_MAX)) begin
               stag_in = stag_ff + lagc_pkg::STAG_W'(1);
            end
            prev_count_in          = live_sat;
            rsp_valid_in           = 1'b1;
            rsp_data_in.read_value = 1'b0;
            rsp_data_in.live_count = live_sat;
            rsp_data_in.stagnant   = (stag_in > lagc_pkg::STAG_LIMIT);
            state_in               = lagc_pkg::ST_IDLE;
         end
         default: state_in = lagc_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lagc_pkg::ST_IDLE;
         cfg_width_ff  <= lagc_pkg::GRID_WIDTH_RST;
         cfg_height_ff <= lagc_pkg::GRID_HEIGHT_RST;
         cfg_wrap_ff   <= 1'b0;
         row_valid_ff  <= '0;
         stag_ff       <= '0;
         prev_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cfg_width_ff  <= cfg_width_in;
         cfg_height_ff <= cfg_height_in;
         cfg_wrap_ff   <= cfg_wrap_in;
         row_valid_ff  <= row_valid_in;
         stag_ff       <= stag_in;
         prev_count_ff <= prev_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cv_ff       <= cv_in;
      inside_ff   <= inside_in;
      area_ff     <= area_in;
      live_ff     <= live_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      nxt_ff      <= nxt_in;
      row0_ff     <= row0_in;
      new_row_ff  <= new_row_in;
   end

   // row store, one write and one registered read per cycle; invalid rows read as dead
   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_row_ff <= row_valid_ff[mem_ra] ? row_mem[mem_ra] : '0;
      end
   end

   `LAGC_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy, "start beat not taken")
   `LAGC_ASSERT_NXT(a_rsp_single, clock, reset, rsp_valid_ff, !rsp_valid_ff, "double beat")
   `LAGC_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == lagc_pkg::ST_IDLE, "beat while busy")
   `LAGC_ASSERT_IMP(a_x_range, clock, reset, state_ff == lagc_pkg::ST_GEN_CELL, DIM_W'(x_ff) < w_eff, "column past grid")
   `LAGC_ASSERT_NXT(a_stag_mono, clock, reset, 1'b1, stag_ff >= $past(stag_ff), "stagnation counter fell")

endmodule

[bench/life_gen_checker.sv]
// Checker for the life automaton generation core: mirrors the grid and compares every result.
`timescale 1ns / 1ps
module life_gen_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic                               busy,
   input  lagc_pkg::req_type                  req_data,
   input  logic                               rsp_valid,
   input  lagc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [lagc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lagc_pkg::CFG_DIM_W-1:0]     csr_wdata,
   output int                                 fail_count,
   output int                                 pending
);

   localparam int ROW_SPAN   = lagc_pkg::MAX_WIDTH_DEF;
   localparam int GRID_CELLS = lagc_pkg::MAX_WIDTH_DEF * lagc_pkg::MAX_HEIGHT_DEF;

   bit                                  life_grid [GRID_CELLS];
   bit                                  fresh_grid [GRID_CELLS];
   logic [lagc_pkg::CFG_DIM_W-1:0]      cfg_width;
   logic [lagc_pkg::CFG_DIM_W-1:0]      cfg_height;
   bit                                  cfg_wrap;
   logic [lagc_pkg::COUNT_W-1:0]        last_live;
   logic [lagc_pkg::STAG_W-1:0]         flat_gens;
   lagc_pkg::rsp_type                   awaited_rsp [$];
   int                                  errs = 0;

   function automatic int span(input logic [lagc_pkg::CFG_DIM_W-1:0] v, input int limit);
      if (v == 0) return 1;
      if (v > limit) return limit;
      return v;
   endfunction

   function automatic bit neighbour(input int x, input int y, input int dx, input int dy,
                                    input int w, input int h);
      int nx, ny;
      nx = x + dx;
      ny = y + dy;
      if (nx < 0 || nx >= w) begin
         if (!cfg_wrap) return 1'b0;
         nx = (nx < 0) ? w - 1 : 0;
      end
      if (ny < 0 || ny >= h) begin
         if (!cfg_wrap) return 1'b0;
         ny = (ny < 0) ? h - 1 : 0;
      end
      return life_grid[ny * ROW_SPAN + nx];
   endfunction

   // B3/S23 over the grid in use; everything outside it ends up dead
   function automatic int evolve_grid(input int w, input int h);
      int live, n;
      live = 0;
      foreach (fresh_grid[i]) fresh_grid[i] = 1'b0;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++)
               for (int dx = -1; dx <= 1; dx++)
                  if (dx != 0 || dy != 0) n += neighbour(x, y, dx, dy, w, h);
            if (life_grid[y * ROW_SPAN + x]) begin
               live++;
               fresh_grid[y * ROW_SPAN + x] = (n == 2 || n == 3);
            end else begin
               fresh_grid[y * ROW_SPAN + x] = (n == 3);
            end
         end
      end
      life_grid = fresh_grid;
      return live;
   endfunction

   function automatic lagc_pkg::rsp_type predict_cmd(input lagc_pkg::req_type cmd);
      lagc_pkg::rsp_type res;
      int w, h, live, slot;
      bit in_grid;
      w = span(cfg_width, lagc_pkg::MAX_WIDTH_DEF);
      h = span(cfg_height, lagc_pkg::MAX_HEIGHT_DEF);
      in_grid = (int'(cmd.cell_x) < w) && (int'(cmd.cell_y) < h);
      slot = int'(cmd.cell_y) * ROW_SPAN + int'(cmd.cell_x);
      res = '0;
      case (cmd.op)
         lagc_pkg::OP_WRITE: begin
            if (in_grid) life_grid[slot] = cmd.cell_value;
         end
         lagc_pkg::OP_READ: begin
            if (in_grid) res.read_value = life_grid[slot];
         end
         lagc_pkg::OP_STEP: begin
            live = evolve_grid(w, h);
            res.live_count = (live > lagc_pkg::COUNT_MAX) ? lagc_pkg::COUNT_MAX : live[12:0];
            if (res.live_count == last_live && 5 * live < w * h &&
                flat_gens < lagc_pkg::STAG_MAX)
               flat_gens = flat_gens + 1'b1;
            last_live = res.live_count;
         end
         default: ;
      endcase
      res.stagnant = (flat_gens > lagc_pkg::STAG_LIMIT);
      return res;
   endfunction

   function automatic void flag_field(input string field, input int want, input int got);
      errs++;
      $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
   endfunction

   task automatic check_rsp(input lagc_pkg::rsp_type got);
      lagc_pkg::rsp_type want;
      if (awaited_rsp.size() == 0) begin
         errs++;
         $display("%0t: result beat with nothing awaited, expected none actual %0d/%0d/%0d",
                  $time, got.read_value, got.live_count, got.stagnant);
         return;
      end
      want = awaited_rsp.pop_front();
      if (got.read_value !== want.read_value)
         flag_field("read_value", want.read_value, got.read_value);
      if (got.live_count !== want.live_count)
         flag_field("live_count", want.live_count, got.live_count);
      if (got.stagnant !== want.stagnant)
         flag_field("stagnant", want.stagnant, got.stagnant);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (life_grid[i]) life_grid[i] = 1'b0;
         cfg_width  = lagc_pkg::GRID_WIDTH_RST;
         cfg_height = lagc_pkg::GRID_HEIGHT_RST;
         cfg_wrap   = 1'b0;
         last_live  = '0;
         flat_gens  = '0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid) check_rsp(rsp_data);
         if (csr_we) begin
            case (csr_index)
               lagc_pkg::CSR_GRID_WIDTH:  cfg_width  = csr_wdata;
               lagc_pkg::CSR_GRID_HEIGHT: cfg_height = csr_wdata;
               lagc_pkg::CSR_WRAP_EDGES:  cfg_wrap   = csr_wdata[0];
               default: ;
            endcase
         end
         if (start && !busy) awaited_rsp.push_back(predict_cmd(req_data));
      end
      pending    <= awaited_rsp.size();
      fail_count <= errs;
   end

endmodule

[bench/tb.sv]
// Top of the bench: drives commands and grid settings into the core and gives the verdict.
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 2000000;

   logic                               clock;
   logic                               reset;
   logic                               start;
   logic                               busy;
   lagc_pkg::req_type                  req_data;
   logic                               rsp_valid;
   lagc_pkg::rsp_type                  rsp_data;
   logic                               csr_we;
   logic [lagc_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [lagc_pkg::CFG_DIM_W-1:0]     csr_wdata;

   int fail_count;
   int pending;
   int cycles = 0;
   int beats_sent = 0;
   int grid_w = 64;
   int grid_h = 64;
   bit gaps_on = 1'b0;
   bit big;

   life_automaton_generation_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   life_gen_checker life_check (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("life_automaton_generation_core verification failed");
         $finish;
      end
   end

   task automatic program_grid(input logic [6:0] w, input logic [6:0] h, input bit wrap);
      csr_we    <= 1'b1;
      csr_index <= lagc_pkg::CSR_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= lagc_pkg::CSR_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_index <= lagc_pkg::CSR_WRAP_EDGES;
      csr_wdata <= {6'd0, wrap};
      @(posedge clock);
      csr_we    <= 1'b0;
      grid_w = (w == 0) ? 1 : ((w > lagc_pkg::MAX_WIDTH_DEF) ? lagc_pkg::MAX_WIDTH_DEF : w);
      grid_h = (h == 0) ? 1 : ((h > lagc_pkg::MAX_HEIGHT_DEF) ? lagc_pkg::MAX_HEIGHT_DEF : h);
   endtask

   // start stays high from one beat to the next unless a gap is taken
   task automatic issue(input logic [1:0] op, input int x, input int y, input bit v);
      lagc_pkg::req_type beat;
      beat.op         = op;
      beat.cell_x     = x[5:0];
      beat.cell_y     = y[5:0];
      beat.cell_value = v;
      if (gaps_on && $urandom_range(0, 2) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // full 64 by 64 grid, dead edges: corner block plus a lone far corner cell
      issue(lagc_pkg::OP_READ, 63, 63, 1'b0);
      issue(lagc_pkg::OP_WRITE, 0, 0, 1'b1);
      issue(lagc_pkg::OP_WRITE, 1, 0, 1'b1);
      issue(lagc_pkg::OP_WRITE, 0, 1, 1'b1);
      issue(lagc_pkg::OP_WRITE, 1, 1, 1'b1);
      issue(lagc_pkg::OP_WRITE, 63, 63, 1'b1);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      issue(lagc_pkg::OP_STEP, 63, 63, 1'b1);
      issue(lagc_pkg::OP_READ, 1, 1, 1'b0);
      issue(lagc_pkg::OP_READ, 63, 63, 1'b0);
      issue(OP_UNUSED, 63, 63, 1'b1);
      settle();

      // 3 by 3 torus with a blinker
      program_grid(7'd3, 7'd3, 1'b1);
      issue(lagc_pkg::OP_WRITE, 0, 1, 1'b1);
      issue(lagc_pkg::OP_WRITE, 1, 1, 1'b1);
      issue(lagc_pkg::OP_WRITE, 2, 1, 1'b1);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      issue(lagc_pkg::OP_READ, 1, 0, 1'b0);
      issue(lagc_pkg::OP_WRITE, 2, 2, 1'b1);
      settle();

      // width 0 acts as 1, height above range acts as maximum; outside cells ignored
      program_grid(7'd0, 7'd127, 1'b1);
      issue(lagc_pkg::OP_WRITE, 1, 5, 1'b1);
      issue(lagc_pkg::OP_READ, 1, 5, 1'b0);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      settle();

      // cell beyond the narrowed grid must have been cleared by that step
      program_grid(7'd3, 7'd64, 1'b0);
      issue(lagc_pkg::OP_READ, 2, 2, 1'b0);
      settle();

      program_grid(7'd2, 7'd2, 1'b1);
      issue(lagc_pkg::OP_WRITE, 0, 0, 1'b1);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      settle();

      program_grid(7'd64, 7'd1, 1'b0);
      issue(lagc_pkg::OP_STEP, 0, 0, 1'b0);
      settle();

      // random phases: seed a pattern, run a few generations, sample cells
      while (beats_sent < 135) begin
         big = ($urandom_range(0, 7) == 0);
         if (big)
            program_grid(7'($urandom_range(33, 127)), 7'($urandom_range(33, 127)),
                         1'($urandom_range(0, 1)));
         else
            program_grid(7'($urandom_range(0, 12)), 7'($urandom_range(0, 12)),
                         1'($urandom_range(0, 1)));
         gaps_on = (beats_sent < 110) && ($urandom_range(0, 3) != 0);
         repeat (big ? $urandom_range(4, 12) : $urandom_range(2, 10)) begin
            if ($urandom_range(0, 9) == 0)
               issue(2'($urandom_range(0, 3)), $urandom_range(0, 63), $urandom_range(0, 63),
                     1'($urandom_range(0, 1)));
            else
               issue(lagc_pkg::OP_WRITE, $urandom_range(0, grid_w - 1),
                     $urandom_range(0, grid_h - 1), $urandom_range(0, 3) != 0);
         end
         repeat (big ? $urandom_range(1, 2) : $urandom_range(2, 6)) begin
            issue(lagc_pkg::OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
            repeat ($urandom_range(0, 2))
               issue(lagc_pkg::OP_READ, $urandom_range(0, grid_w - 1),
                     $urandom_range(0, grid_h - 1), 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 3) == 0)
            issue(lagc_pkg::OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                  1'($urandom_range(0, 1)));
         settle();
      end

      gaps_on = 1'b0;
      repeat (12) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("life_automaton_generation_core verification clean");
      else
         $display("life_automaton_generation_core verification failed");
      $finish;
   end

endmodule
